>>> design/bspq_pkg.sv
// bspq_pkg: beat types, entry type and operation/status codes for the
// bounded stable priority queue
// no dependencies
package bspq_pkg;

	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned TAG_W   = 32;
	localparam int unsigned TOTAL_W = 7;
	localparam int unsigned LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// operation codes
	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_POP   = 2'd1;
	localparam logic [1:0] FUNC_CLOSE = 2'd2;
	localparam logic [1:0] FUNC_NOP   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_CLOSED = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]  cmd_tag;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [PRIO_W-1:0]  out_priority;
		logic [TAG_W-1:0]   out_tag;
		logic [TOTAL_W-1:0] entry_total;
	} out_beat_t;

	// one stored queue entry
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

endpackage

>>> design/bounded_stable_priority_queue.sv
// bounded_stable_priority_queue: top level, limit register plus sequencer
// and entry storage
// depends on bspq_pkg, bspq_mem, bspq_seq
//
// Commands enter on start while busy is low; each gives exactly one result,
// shown on rsp for a single cycle with done high, which the receiver must take
// as it comes. Entries sit sorted in a circular store (head is the next to
// leave), so pop, shutdown, refused pushes, no-ops and a push into an empty
// store finish without a walk: their result appears the cycle after start,
// except a pop, which holds busy in S_POP while the head is read and so
// shows its result after that state. An accepted push into a non-empty store
// walks back from the tail one stored entry per cycle through the single
// priority comparator and memory read port, shifting lower entries down; it
// stays in S_SCAN until it meets an entry of equal or higher priority, or,
// with every entry shifted, goes to S_PLACE; its result appears as busy
// drops. No clearing pass follows reset. limit_q resets to 64; the user must
// write it via cfg_we/cfg_data only while idle, as the block does not check.
module bounded_stable_priority_queue #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bspq_pkg::in_beat_t           cmd,
	output logic                         busy,
	output logic                         done,
	output bspq_pkg::out_beat_t          rsp,
	input  logic                         cfg_we,
	input  logic [bspq_pkg::LIMIT_W-1:0] cfg_data
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [bspq_pkg::LIMIT_W-1:0] limit_q;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [AW-1:0]                mem_raddr;
	bspq_pkg::entry_t             mem_wdata;
	bspq_pkg::entry_t             mem_rdata;

	// queue limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bspq_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	bspq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.limit     (limit_q),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bspq_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

>>> design/bspq_mem.sv
// bspq_mem: entry storage, one write port and one registered read port
// depends on bspq_pkg (entry_t)
module bspq_mem #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  bspq_pkg::entry_t              wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output bspq_pkg::entry_t              rdata
);

	bspq_pkg::entry_t mem_q [DEPTH];
	bspq_pkg::entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/bspq_seq.sv
// bspq_seq: sequencer that walks the stored entries through one compare unit,
// keeps head/tail pointers of the circular sorted store and builds results
// depends on bspq_pkg (beat types, codes)
module bspq_seq #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  bspq_pkg::in_beat_t                cmd,
	input  logic [bspq_pkg::LIMIT_W-1:0]      limit,
	output logic                              busy,
	output logic                              done,
	output bspq_pkg::out_beat_t               rsp,
	output logic                              mem_we,
	output logic [$clog2(DEPTH)-1:0]          mem_waddr,
	output bspq_pkg::entry_t                  mem_wdata,
	output logic [$clog2(DEPTH)-1:0]          mem_raddr,
	input  bspq_pkg::entry_t                  mem_rdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_POP
	} state_t;

	state_t              state_q, state_d;
	logic [AW-1:0]       head_q, head_d;
	logic [AW-1:0]       tail_q, tail_d;
	logic [CW-1:0]       count_q, count_d;
	logic                closed_q, closed_d;
	logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
	logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
	logic [CW-1:0]       left_q, left_d;
	bspq_pkg::entry_t    new_q, new_d;
	logic                done_q, done_d;
	bspq_pkg::out_beat_t rsp_q, rsp_d;
	logic                full;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		ptr_dec = (p == '0) ? LAST : p - AW'(1);
	endfunction

	function automatic logic [bspq_pkg::TOTAL_W-1:0] to_total(input logic [CW-1:0] c);
		logic [31:0] wide;
		wide = 32'(c);
		to_total = wide[bspq_pkg::TOTAL_W-1:0];
	endfunction

	// refuse a push at the configured limit or at the store size
	assign full = (32'(count_q) >= 32'(limit)) || (32'(count_q) >= 32'(DEPTH));

	// next-state and memory control
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		closed_d  = closed_q;
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		left_d    = left_q;
		new_d     = new_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = new_q;
		mem_raddr = ptr_dec(rd_ptr_q);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					rsp_d.status       = bspq_pkg::ST_OK;
					rsp_d.out_priority = '0;
					rsp_d.out_tag      = '0;
					rsp_d.entry_total  = to_total(count_q);
					new_d.prio         = cmd.priority_req;
					new_d.tag          = cmd.cmd_tag;
					unique case (cmd.func)
						bspq_pkg::FUNC_PUSH: begin
							if (closed_q) begin
								rsp_d.status = bspq_pkg::ST_CLOSED;
								done_d       = 1'b1;
							end else if (full) begin
								rsp_d.status = bspq_pkg::ST_FULL;
								done_d       = 1'b1;
							end else if (count_q == '0) begin
								// empty store: new entry goes straight to the tail
								mem_we            = 1'b1;
								mem_waddr         = tail_q;
								mem_wdata         = new_d;
								tail_d            = ptr_inc(tail_q);
								count_d           = count_q + CW'(1);
								rsp_d.entry_total = to_total(count_d);
								done_d            = 1'b1;
							end else begin
								// walk back from the last entry
								mem_raddr = ptr_dec(tail_q);
								rd_ptr_d  = ptr_dec(tail_q);
								wr_ptr_d  = tail_q;
								left_d    = count_q - CW'(1);
								state_d   = S_SCAN;
							end
						end
						bspq_pkg::FUNC_POP: begin
							if (count_q == '0) begin
								rsp_d.status = bspq_pkg::ST_EMPTY;
								done_d       = 1'b1;
							end else begin
								mem_raddr = head_q;
								state_d   = S_POP;
							end
						end
						bspq_pkg::FUNC_CLOSE: begin
							closed_d = 1'b1;
							done_d   = 1'b1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				mem_we = 1'b1;
				if (mem_rdata.prio < new_q.prio) begin
					// shift the lower entry one slot toward the tail
					mem_wdata = mem_rdata;
					wr_ptr_d  = rd_ptr_q;
					if (left_q == '0) begin
						state_d = S_PLACE;
					end else begin
						rd_ptr_d = ptr_dec(rd_ptr_q);
						left_d   = left_q - CW'(1);
					end
				end else begin
					// equal or higher priority stays ahead: insert behind it
					mem_wdata         = new_q;
					tail_d            = ptr_inc(tail_q);
					count_d           = count_q + CW'(1);
					rsp_d.entry_total = to_total(count_d);
					done_d            = 1'b1;
					state_d           = S_IDLE;
				end
			end
			S_PLACE: begin
				mem_we            = 1'b1;
				mem_wdata         = new_q;
				tail_d            = ptr_inc(tail_q);
				count_d           = count_q + CW'(1);
				rsp_d.entry_total = to_total(count_d);
				done_d            = 1'b1;
				state_d           = S_IDLE;
			end
			S_POP: begin
				rsp_d.out_priority = mem_rdata.prio;
				rsp_d.out_tag      = mem_rdata.tag;
				head_d             = ptr_inc(head_q);
				count_d            = count_q - CW'(1);
				rsp_d.entry_total  = to_total(count_d);
				done_d             = 1'b1;
				state_d            = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			closed_q <= closed_d;
			done_q   <= done_d;
		end
	end

	// walk pointers and payload
	always_ff @(posedge clk) begin
		rd_ptr_q <= rd_ptr_d;
		wr_ptr_q <= wr_ptr_d;
		left_q   <= left_d;
		new_q    <= new_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// count never passes the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DEPTH))
		else $error("entry count above store size");

	// tail stays count slots past head
	a_ptr_span: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) + 32'(count_q) == 32'(tail_q)) ||
		(32'(head_q) + 32'(count_q) == 32'(tail_q) + 32'(DEPTH)))
		else $error("head/tail out of step with count");

	// walk never looks past the stored entries
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (left_q < count_q))
		else $error("walk beyond stored entries");

	// shutdown only taken with a result
	a_close_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(closed_q) |-> done_q)
		else $error("shutdown without result");

	// shutdown flag is sticky
	a_close_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("shutdown flag cleared");

endmodule

>>> tb/bspq_checker.sv
// bspq_checker: watches the command and result channels of the priority queue,
// predicts every result beat and compares it field by field
// depends on bspq_pkg
module bspq_checker #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  bspq_pkg::in_beat_t           cmd,
	input  logic                         done,
	input  bspq_pkg::out_beat_t          rsp,
	input  logic                         cfg_we,
	input  logic [bspq_pkg::LIMIT_W-1:0] cfg_data,
	output int unsigned                  pending,
	output int unsigned                  fail_count
);
	import bspq_pkg::*;

	// predicted queue contents, head at index 0
	entry_t             sorted_q[$];
	logic               shut_down;
	logic [LIMIT_W-1:0] limit_reg;
	out_beat_t          rsp_expect_q[$];
	int unsigned        mismatches;

	// apply one command beat to the predicted queue and return its result beat
	function automatic out_beat_t apply_command(in_beat_t c);
		out_beat_t   r;
		entry_t      e;
		int unsigned pos;
		r = '0;
		case (c.func)
			FUNC_PUSH: begin
				if (shut_down) begin
					r.status = ST_CLOSED;
				end else if (sorted_q.size() >= int'(limit_reg) || sorted_q.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// equal priorities stay in arrival order
					pos = 0;
					while (pos < sorted_q.size() && sorted_q[pos].prio >= c.priority_req)
						pos++;
					e.prio = c.priority_req;
					e.tag  = c.cmd_tag;
					sorted_q.insert(pos, e);
					r.status = ST_OK;
				end
			end
			FUNC_POP: begin
				if (sorted_q.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					e = sorted_q.pop_front();
					r.status       = ST_OK;
					r.out_priority = e.prio;
					r.out_tag      = e.tag;
				end
			end
			FUNC_CLOSE: begin
				shut_down = 1'b1;
				r.status  = ST_OK;
			end
			default: begin
				r.status = ST_OK;
			end
		endcase
		r.entry_total = TOTAL_W'(sorted_q.size());
		return r;
	endfunction

	// result check first, then prediction of a newly accepted beat
	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_beat;
		if (!arst_n) begin
			sorted_q.delete();
			rsp_expect_q.delete();
			shut_down  = 1'b0;
			limit_reg  = LIMIT_RESET;
			mismatches = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (rsp_expect_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result beat st=%0d prio=%0d tag=%h total=%0d",
							$realtime, rsp.status, rsp.out_priority, rsp.out_tag,
							rsp.entry_total);
					mismatches++;
				end else begin
					exp_beat = rsp_expect_q.pop_front();
					if (rsp.status !== exp_beat.status ||
					    rsp.out_priority !== exp_beat.out_priority ||
					    rsp.out_tag !== exp_beat.out_tag ||
					    rsp.entry_total !== exp_beat.entry_total) begin
						if (mismatches < 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected st=%0d prio=%0d tag=%h total=%0d",
								exp_beat.status, exp_beat.out_priority,
								exp_beat.out_tag, exp_beat.entry_total);
							$display("  actual   st=%0d prio=%0d tag=%h total=%0d",
								rsp.status, rsp.out_priority, rsp.out_tag,
								rsp.entry_total);
						end
						mismatches++;
					end
				end
			end
			if (start && !busy)
				rsp_expect_q.push_back(apply_command(cmd));
			if (cfg_we)
				limit_reg = cfg_data;
			pending    <= rsp_expect_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

>>> tb/testbench.sv
// testbench: clock, reset and command stimulus for the bounded stable
// priority queue, with a watchdog and the final verdict
// depends on bspq_pkg, bounded_stable_priority_queue, bspq_checker
module testbench;
	import bspq_pkg::*;

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned STALL_LIMIT = 4000;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	in_beat_t           cmd      = '0;
	logic               cfg_we   = 1'b0;
	logic [LIMIT_W-1:0] cfg_data = '0;
	logic               busy;
	logic               done;
	out_beat_t          rsp;
	int unsigned        pending;
	int unsigned        fail_count;
	int unsigned        burst_left  = 1;
	int unsigned        idle_cycles = 0;

	always #4 clk = ~clk;

	bounded_stable_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	bspq_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.fail_count(fail_count)
	);

	// send one command beat, then maybe drop start for a random gap
	task automatic issue(logic [1:0] f, logic [PRIO_W-1:0] p, logic [TAG_W-1:0] t);
		in_beat_t    b;
		int unsigned gap;
		b.func         = f;
		b.priority_req = p;
		b.cmd_tag      = t;
		start <= 1'b1;
		cmd   <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(60, 1);
			gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(20, 1);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every result beat is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// random command, ties in priority made common
	task automatic random_item(int unsigned push_pct, int unsigned close_pct);
		int unsigned       roll;
		logic [1:0]        f;
		logic [PRIO_W-1:0] p;
		roll = $urandom_range(99, 0);
		if (roll < close_pct)
			f = FUNC_CLOSE;
		else if (roll < close_pct + push_pct)
			f = FUNC_PUSH;
		else if (roll < 97)
			f = FUNC_POP;
		else
			f = FUNC_NOP;
		case ($urandom_range(3, 0))
			0, 1:    p = PRIO_W'($urandom_range(3, 0));
			2:       p = PRIO_W'($urandom);
			default: p = ($urandom_range(1, 0) != 0) ? 8'hff : 8'h00;
		endcase
		issue(f, p, $urandom);
	endtask

	task automatic run_phase(logic [LIMIT_W-1:0] lim, int unsigned push_pct, int unsigned n);
		write_limit(lim);
		repeat (n) random_item(push_pct, 0);
	endtask

	// stall watchdog: cycles with no beat accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, ties, no-op, drain in order
		issue(FUNC_POP, 8'h00, 32'h0);
		issue(FUNC_PUSH, 8'h00, 32'h0000_0000);
		issue(FUNC_PUSH, 8'hff, 32'hffff_ffff);
		issue(FUNC_PUSH, 8'hff, 32'h0000_0001);
		issue(FUNC_PUSH, 8'h80, 32'h5a5a_a5a5);
		issue(FUNC_NOP, 8'hff, 32'hdead_beef);
		issue(FUNC_PUSH, 8'h00, 32'h0000_0005);
		repeat (5) issue(FUNC_POP, 8'h55, 32'h1234_5678);
		issue(FUNC_POP, 8'haa, 32'h8765_4321);

		// zero limit refuses every push
		write_limit(7'd0);
		issue(FUNC_PUSH, 8'h10, 32'h0000_0010);

		// limit of two: third push is full
		write_limit(7'd2);
		issue(FUNC_PUSH, 8'h01, 32'h0000_0101);
		issue(FUNC_PUSH, 8'h02, 32'h0000_0102);
		issue(FUNC_PUSH, 8'h03, 32'h0000_0103);
		issue(FUNC_POP, 8'h00, 32'h0);
		issue(FUNC_POP, 8'h00, 32'h0);

		// random phases over several limits, shutdown kept for the end
		run_phase(7'd64, 60, 300);
		run_phase(7'd5, 55, 300);
		run_phase(7'd127, 85, 200);
		run_phase(7'd0, 50, 60);
		run_phase(7'd1, 50, 250);
		run_phase(LIMIT_W'($urandom_range(20, 2)), 55, 300);
		run_phase(7'd64, 50, 200);

		// full queue then shutdown: closed wins over full
		write_limit(7'd3);
		repeat (3) random_item(100, 0);
		issue(FUNC_CLOSE, 8'h00, 32'h0);
		issue(FUNC_PUSH, 8'hff, 32'hffff_ffff);
		repeat (150) random_item(45, 5);
		repeat (4) issue(FUNC_POP, 8'h00, 32'h0);
		issue(FUNC_CLOSE, 8'hff, 32'hffff_ffff);
		issue(FUNC_NOP, 8'h00, 32'h0);

		drain();
		repeat (2 * DEPTH) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
